[hdl/ferl_pkg.sv]
// Shared types and constants for the fault event ring logger.
package ferl_pkg;

  typedef enum logic [2:0] {
    ACT_RECORD      = 3'd0,
    ACT_CTRL_FRAME  = 3'd1,
    ACT_TIMING      = 3'd2,
    ACT_READ_EVENT  = 3'd3,
    ACT_FIRST_FAULT = 3'd4,
    ACT_FAULT_FRAME = 3'd5,
    ACT_FIRST_LOOP  = 3'd6,
    ACT_CLEAR       = 3'd7
  } ferl_action_e;

  localparam logic [1:0] FLAG_FATAL = 2'b01;
  localparam logic [1:0] FLAG_FIRST = 2'b10;

  typedef struct packed {
    ferl_action_e action;
    logic         fatal;
    logic [31:0]  error_code;
    logic [63:0]  snapshot_in;
    logic [31:0]  cycle_in;
    logic         complete_in;
    logic [31:0]  detail_in;
    logic [31:0]  after_seq;
  } ferl_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] event_number;
    logic [31:0] event_error;
    logic [1:0]  event_flags;
    logic [63:0] snapshot_out;
    logic [31:0] cycle_out;
    logic        complete_out;
    logic [31:0] detail_out;
  } ferl_out_t;

  typedef struct packed {
    logic [31:0] number;
    logic [31:0] error;
    logic [1:0]  flags;
  } ferl_entry_t;

endpackage

[hdl/ferl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module ferl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/fault_event_ring_logger.sv]
// Top level of the fault event ring logger: event ring, first-fault latch, timing records.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------
//   in      | input     | in_valid_i/in_stall_o   | ferl_in_t
//   out     | output    | out_valid_o/out_stall_i | ferl_out_t
//
// Every action except a read event on a non-empty ring gives its result in the cycle after the transfer.
// Read event scans at most fill entries, oldest first: the ring RAM gives one entry per cycle.
// Input is taken only while no scan runs and the output register is free or draining.
// Reset and the clear action zero the fill count, so no RAM clearing pass is needed.
// A stalled result holds in the output register; a scan waits with its RAM data held.
module fault_event_ring_logger
  import ferl_pkg::*;
#(
  parameter int LOG_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ferl_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ferl_out_t out_data_o
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int FW = $clog2(LOG_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] seq_q, seq_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [AW-1:0] wslot_q, wslot_d;
  logic [31:0] first_num_q, first_num_d;
  logic [31:0] first_err_q, first_err_d;
  logic [1:0]  first_flags_q, first_flags_d;
  logic [63:0] latest_snap_q, latest_snap_d;
  logic [63:0] fault_snap_q, fault_snap_d;
  logic [31:0] latest_cyc_q, latest_cyc_d;
  logic [31:0] latest_det_q, latest_det_d;
  logic        latest_cmp_q, latest_cmp_d;
  logic [31:0] fault_cyc_q, fault_cyc_d;
  logic [31:0] fault_det_q, fault_det_d;
  logic        fault_cmp_q, fault_cmp_d;
  logic [31:0] fl_cyc_q, fl_cyc_d;
  logic [31:0] fl_det_q, fl_det_d;
  logic        fl_cmp_q, fl_cmp_d;
  logic [AW-1:0] scan_addr_q, scan_addr_d;
  logic [FW-1:0] scan_cnt_q, scan_cnt_d;
  logic [31:0] after_q, after_d;
  logic        out_valid_q, out_valid_d;
  ferl_out_t   out_q, out_d;

  logic          out_free, in_accept;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr, start_addr;
  ferl_entry_t   ram_wdata, ram_rdata;
  logic [FW-1:0] wslot_ext;
  logic          hit, last;
  logic [31:0]   num;
  logic [1:0]    rec_flags;
  ferl_out_t     res;
  logic          res_load;

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    next_addr = (a == AW'(LOG_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  ferl_ram #(
    .WIDTH ($bits(ferl_entry_t)),
    .DEPTH (LOG_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign wslot_ext  = FW'(wslot_q);
  assign start_addr = (wslot_ext >= fill_q) ? AW'(wslot_ext - fill_q)
                                            : AW'(wslot_ext + FW'(LOG_DEPTH) - fill_q);

  assign hit  = ram_rdata.number > after_q;
  assign last = scan_cnt_q == (fill_q - 1'b1);
  assign num  = seq_q + 32'd1;

  always_comb begin
    state_d       = state_q;
    seq_d         = seq_q;
    fill_d        = fill_q;
    wslot_d       = wslot_q;
    first_num_d   = first_num_q;
    first_err_d   = first_err_q;
    first_flags_d = first_flags_q;
    latest_snap_d = latest_snap_q;
    fault_snap_d  = fault_snap_q;
    latest_cyc_d  = latest_cyc_q;
    latest_det_d  = latest_det_q;
    latest_cmp_d  = latest_cmp_q;
    fault_cyc_d   = fault_cyc_q;
    fault_det_d   = fault_det_q;
    fault_cmp_d   = fault_cmp_q;
    fl_cyc_d      = fl_cyc_q;
    fl_det_d      = fl_det_q;
    fl_cmp_d      = fl_cmp_q;
    scan_addr_d   = scan_addr_q;
    scan_cnt_d    = scan_cnt_q;
    after_d       = after_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = start_addr;
    rec_flags     = in_data_i.fatal ? FLAG_FATAL : 2'b00;
    res           = '0;
    res_load      = 1'b0;

    if (in_data_i.fatal && (first_num_q == 32'd0)) begin
      rec_flags = rec_flags | FLAG_FIRST;
    end
    ram_wdata.number = num;
    ram_wdata.error  = in_data_i.error_code;
    ram_wdata.flags  = rec_flags;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_load = 1'b1;
          case (in_data_i.action)
            ACT_RECORD: begin
              ram_we  = 1'b1;
              seq_d   = num;
              wslot_d = next_addr(wslot_q);
              if (fill_q != FW'(LOG_DEPTH)) begin
                fill_d = fill_q + 1'b1;
              end
              if (in_data_i.fatal && (first_num_q == 32'd0)) begin
                first_num_d   = num;
                first_err_d   = in_data_i.error_code;
                first_flags_d = rec_flags;
                fault_snap_d  = latest_snap_q;
                fault_cyc_d   = latest_cyc_q;
                fault_det_d   = latest_det_q;
                fault_cmp_d   = latest_cmp_q;
              end
            end
            ACT_CTRL_FRAME, ACT_TIMING: begin
              if (in_data_i.action == ACT_CTRL_FRAME) begin
                latest_snap_d = in_data_i.snapshot_in;
              end
              latest_cyc_d = in_data_i.cycle_in;
              latest_det_d = in_data_i.detail_in;
              latest_cmp_d = in_data_i.complete_in;
              if (in_data_i.complete_in && (fl_cyc_q == 32'd0)) begin
                fl_cyc_d = in_data_i.cycle_in;
                fl_det_d = in_data_i.detail_in;
                fl_cmp_d = in_data_i.complete_in;
              end
            end
            ACT_READ_EVENT: begin
              if (fill_q != '0) begin
                res_load    = 1'b0;
                ram_re      = 1'b1;
                scan_addr_d = next_addr(start_addr);
                scan_cnt_d  = '0;
                after_d     = in_data_i.after_seq;
                state_d     = ST_SCAN;
              end
            end
            ACT_FIRST_FAULT: begin
              if (first_num_q != 32'd0) begin
                res.found        = 1'b1;
                res.event_number = first_num_q;
                res.event_error  = first_err_q;
                res.event_flags  = first_flags_q;
              end
            end
            ACT_FAULT_FRAME: begin
              res.snapshot_out = fault_snap_q;
              res.cycle_out    = fault_cyc_q;
              res.complete_out = fault_cmp_q;
              res.detail_out   = fault_det_q;
            end
            ACT_FIRST_LOOP: begin
              res.cycle_out    = fl_cyc_q;
              res.complete_out = fl_cmp_q;
              res.detail_out   = fl_det_q;
            end
            default: begin
              seq_d         = '0;
              fill_d        = '0;
              wslot_d       = '0;
              first_num_d   = '0;
              first_err_d   = '0;
              first_flags_d = '0;
              latest_snap_d = '0;
              fault_snap_d  = '0;
              latest_cyc_d  = '0;
              latest_det_d  = '0;
              latest_cmp_d  = 1'b0;
              fault_cyc_d   = '0;
              fault_det_d   = '0;
              fault_cmp_d   = 1'b0;
              fl_cyc_d      = '0;
              fl_det_d      = '0;
              fl_cmp_d      = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          if (out_free) begin
            res_load = 1'b1;
            if (hit) begin
              res.found        = 1'b1;
              res.event_number = ram_rdata.number;
              res.event_error  = ram_rdata.error;
              res.event_flags  = ram_rdata.flags;
            end
            state_d = ST_IDLE;
          end
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = scan_addr_q;
          scan_addr_d = next_addr(scan_addr_q);
          scan_cnt_d  = scan_cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      seq_q         <= '0;
      fill_q        <= '0;
      wslot_q       <= '0;
      first_num_q   <= '0;
      first_err_q   <= '0;
      first_flags_q <= '0;
      latest_snap_q <= '0;
      fault_snap_q  <= '0;
      latest_cyc_q  <= '0;
      latest_det_q  <= '0;
      latest_cmp_q  <= 1'b0;
      fault_cyc_q   <= '0;
      fault_det_q   <= '0;
      fault_cmp_q   <= 1'b0;
      fl_cyc_q      <= '0;
      fl_det_q      <= '0;
      fl_cmp_q      <= 1'b0;
      scan_addr_q   <= '0;
      scan_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      seq_q         <= seq_d;
      fill_q        <= fill_d;
      wslot_q       <= wslot_d;
      first_num_q   <= first_num_d;
      first_err_q   <= first_err_d;
      first_flags_q <= first_flags_d;
      latest_snap_q <= latest_snap_d;
      fault_snap_q  <= fault_snap_d;
      latest_cyc_q  <= latest_cyc_d;
      latest_det_q  <= latest_det_d;
      latest_cmp_q  <= latest_cmp_d;
      fault_cyc_q   <= fault_cyc_d;
      fault_det_q   <= fault_det_d;
      fault_cmp_q   <= fault_cmp_d;
      fl_cyc_q      <= fl_cyc_d;
      fl_det_q      <= fl_det_d;
      fl_cmp_q      <= fl_cmp_d;
      scan_addr_q   <= scan_addr_d;
      scan_cnt_q    <= scan_cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    after_q <= after_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/ferl_checker.sv]
// Port-level checker for the fault event ring logger and its bind.
module ferl_checker
  import ferl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input ferl_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ferl_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> $stable(in_data_i))
    else $error("stalled input changed");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.action != ACT_READ_EVENT) |=> out_valid_o)
    else $error("non-read transfer gave no result in the next cycle");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      (out_data_o.event_number == 32'd0) && (out_data_o.event_error == 32'd0) &&
      (out_data_o.event_flags == 2'b00))
    else $error("event fields nonzero without found");

  a_hit_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      (out_data_o.event_number != 32'd0) && (out_data_o.snapshot_out == 64'd0) &&
      (out_data_o.cycle_out == 32'd0) && (out_data_o.detail_out == 32'd0))
    else $error("found result with zero number or timing fields");

endmodule

bind fault_event_ring_logger ferl_checker u_ferl_checker (.*);

[test/tb.sv]
// Self-checking testbench for fault_event_ring_logger: queued stimulus, predictor, result checks.
module tb;
  import ferl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned QUIET_LO   = 2000;
  localparam int unsigned QUIET_HI   = 5000;
  localparam int unsigned HOLD_AFTER = 200;
  localparam int unsigned HOLD_LEN   = 300;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ferl_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ferl_out_t out_data;

  fault_event_ring_logger #(.LOG_DEPTH(RING_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ferl_in_t    pend_q[$];
  ferl_out_t   result_q[$];
  int unsigned errors    = 0;
  int unsigned cyc       = 0;
  int unsigned n_seen    = 0;
  int unsigned hold_left = 0;
  bit          held      = 1'b0;
  logic [31:0] gen_seq   = '0;

  // Predicted logger state
  logic [31:0]  seq_cnt;
  logic [31:0]  ring_num [RING_DEPTH];
  logic [31:0]  ring_err [RING_DEPTH];
  logic [1:0]   ring_flg [RING_DEPTH];
  int unsigned  fill;
  int unsigned  wslot;
  logic [31:0]  ff_number;
  logic [31:0]  ff_error;
  logic [1:0]   ff_flags;
  logic [63:0]  last_snap;
  logic [63:0]  ff_snap;
  logic [63:0]  cur_timing;
  logic [63:0]  ff_timing;
  logic [63:0]  loop_timing;
  logic         last_cmp;
  logic         ff_cmp;
  logic         loop_cmp;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic bit idle_now();
    return ($urandom_range(99) < 26) && !(cyc >= QUIET_LO && cyc < QUIET_HI);
  endfunction

  function automatic void clear_log();
    seq_cnt     = '0;
    fill        = 0;
    wslot       = 0;
    ff_number   = '0;
    ff_error    = '0;
    ff_flags    = '0;
    last_snap   = '0;
    ff_snap     = '0;
    cur_timing  = '0;
    ff_timing   = '0;
    loop_timing = '0;
    last_cmp    = 1'b0;
    ff_cmp      = 1'b0;
    loop_cmp    = 1'b0;
    for (int unsigned j = 0; j < RING_DEPTH; j++) begin
      ring_num[j] = '0;
      ring_err[j] = '0;
      ring_flg[j] = '0;
    end
  endfunction

  function automatic void commit_timing(input ferl_in_t x);
    cur_timing = {x.detail_in, x.cycle_in};
    last_cmp   = x.complete_in;
    if (x.complete_in && loop_timing[31:0] == 32'd0) begin
      loop_timing = cur_timing;
      loop_cmp    = x.complete_in;
    end
  endfunction

  function automatic ferl_out_t predict_log(input ferl_in_t x);
    ferl_out_t   r;
    logic [31:0] num;
    logic [1:0]  fl;
    int unsigned start;
    int unsigned k;
    int unsigned i;
    r = '0;
    case (x.action)
      ACT_RECORD: begin
        num     = seq_cnt + 32'd1;
        fl      = x.fatal ? FLAG_FATAL : 2'b00;
        seq_cnt = num;
        if (x.fatal && ff_number == 32'd0) begin
          fl        = fl | FLAG_FIRST;
          ff_number = num;
          ff_error  = x.error_code;
          ff_flags  = fl;
          ff_snap   = last_snap;
          ff_timing = cur_timing;
          ff_cmp    = last_cmp;
        end
        ring_num[wslot] = num;
        ring_err[wslot] = x.error_code;
        ring_flg[wslot] = fl;
        wslot = (wslot + 1) % RING_DEPTH;
        if (fill < RING_DEPTH) fill++;
      end
      ACT_CTRL_FRAME: begin
        last_snap = x.snapshot_in;
        commit_timing(x);
      end
      ACT_TIMING: commit_timing(x);
      ACT_READ_EVENT: begin
        start = (wslot + RING_DEPTH - fill) % RING_DEPTH;
        for (i = 0; i < fill; i++) begin
          k = (start + i) % RING_DEPTH;
          if (!r.found && ring_num[k] > x.after_seq) begin
            r.found        = 1'b1;
            r.event_number = ring_num[k];
            r.event_error  = ring_err[k];
            r.event_flags  = ring_flg[k];
          end
        end
      end
      ACT_FIRST_FAULT: begin
        if (ff_number != 32'd0) begin
          r.found        = 1'b1;
          r.event_number = ff_number;
          r.event_error  = ff_error;
          r.event_flags  = ff_flags;
        end
      end
      ACT_FAULT_FRAME: begin
        r.snapshot_out = ff_snap;
        r.cycle_out    = ff_timing[31:0];
        r.complete_out = ff_cmp;
        r.detail_out   = ff_timing[63:32];
      end
      ACT_FIRST_LOOP: begin
        r.cycle_out    = loop_timing[31:0];
        r.complete_out = loop_cmp;
        r.detail_out   = loop_timing[63:32];
      end
      default: clear_log();
    endcase
    return r;
  endfunction

  function automatic ferl_in_t mk_item(input ferl_action_e a);
    ferl_in_t x;
    x.action      = a;
    x.fatal       = 1'($urandom_range(1));
    x.error_code  = $urandom;
    x.snapshot_in = {$urandom, $urandom};
    x.cycle_in    = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
    x.complete_in = 1'($urandom_range(1));
    x.detail_in   = $urandom;
    x.after_seq   = $urandom;
    return x;
  endfunction

  // Queue one item, tracking the sequence count so reads can aim near live numbers
  task automatic add(input ferl_in_t x);
    if (x.action == ACT_RECORD) gen_seq = gen_seq + 32'd1;
    if (x.action == ACT_CLEAR) gen_seq = '0;
    pend_q.push_back(x);
  endtask

  task automatic cmp_fld(input string f, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch expected %h actual %h", $time, f, e, a);
    end
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin : drv
    logic took;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      took = in_valid && !in_stall;
      if (took) result_q.push_back(predict_log(in_data));
      if (in_valid && !took) begin
        // stalled transfer holds
      end else if (pend_q.size() != 0 && !idle_now()) begin
        in_valid <= 1'b1;
        in_data  <= pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin : mon
    ferl_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_seen++;
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result expected none actual %h", $time, out_data);
        end else begin
          want = result_q.pop_front();
          cmp_fld("found", want.found, out_data.found);
          cmp_fld("event_number", want.event_number, out_data.event_number);
          cmp_fld("event_error", want.event_error, out_data.event_error);
          cmp_fld("event_flags", want.event_flags, out_data.event_flags);
          cmp_fld("snapshot_out", want.snapshot_out, out_data.snapshot_out);
          cmp_fld("cycle_out", want.cycle_out, out_data.cycle_out);
          cmp_fld("complete_out", want.complete_out, out_data.complete_out);
          cmp_fld("detail_out", want.detail_out, out_data.detail_out);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && n_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stim
    ferl_in_t    x;
    int unsigned r;
    clear_log();

    // Directed: empty reads, cycle-zero complete timing, extremes, first fault, clear
    x = mk_item(ACT_READ_EVENT); x.after_seq = '0; add(x);
    add(mk_item(ACT_FIRST_FAULT));
    add(mk_item(ACT_FAULT_FRAME));
    add(mk_item(ACT_FIRST_LOOP));
    x = mk_item(ACT_TIMING); x.cycle_in = '0; x.complete_in = 1'b1; x.detail_in = '1; add(x);
    add(mk_item(ACT_FIRST_LOOP));
    x = mk_item(ACT_CTRL_FRAME);
    x.snapshot_in = '1; x.cycle_in = '1; x.complete_in = 1'b1; x.detail_in = '0;
    add(x);
    add(mk_item(ACT_FIRST_LOOP));
    x = mk_item(ACT_RECORD); x.fatal = 1'b0; x.error_code = '0; add(x);
    x = mk_item(ACT_RECORD); x.fatal = 1'b0; x.error_code = '1; add(x);
    x = mk_item(ACT_RECORD); x.fatal = 1'b1; add(x);
    x = mk_item(ACT_RECORD); x.fatal = 1'b1; add(x);
    add(mk_item(ACT_FIRST_FAULT));
    add(mk_item(ACT_FAULT_FRAME));
    x = mk_item(ACT_READ_EVENT); x.after_seq = 32'd0; add(x);
    x = mk_item(ACT_READ_EVENT); x.after_seq = 32'd1; add(x);
    x = mk_item(ACT_READ_EVENT); x.after_seq = '1; add(x);
    x = mk_item(ACT_TIMING); x.cycle_in = 32'd7; x.complete_in = 1'b1; add(x);
    add(mk_item(ACT_FIRST_LOOP));
    x = mk_item(ACT_CTRL_FRAME); x.snapshot_in = '0; x.complete_in = 1'b0; add(x);
    add(mk_item(ACT_CLEAR));
    x = mk_item(ACT_READ_EVENT); x.after_seq = '0; add(x);
    add(mk_item(ACT_FIRST_FAULT));
    add(mk_item(ACT_FAULT_FRAME));
    add(mk_item(ACT_FIRST_LOOP));

    repeat (1650) begin
      r = $urandom_range(99);
      if (r < 35) begin
        x = mk_item(ACT_RECORD);
        x.fatal = ($urandom_range(4) == 0);
      end else if (r < 45) begin
        x = mk_item(ACT_CTRL_FRAME);
      end else if (r < 55) begin
        x = mk_item(ACT_TIMING);
      end else if (r < 80) begin
        x = mk_item(ACT_READ_EVENT);
        case ($urandom_range(7))
          0:       x.after_seq = '0;
          1:       x.after_seq = '1;
          2:       ;
          default: x.after_seq = gen_seq - 32'($urandom_range(20));
        endcase
      end else if (r < 85) begin
        x = mk_item(ACT_FIRST_FAULT);
      end else if (r < 90) begin
        x = mk_item(ACT_FAULT_FRAME);
      end else if (r < 96) begin
        x = mk_item(ACT_FIRST_LOOP);
      end else begin
        x = mk_item(ACT_CLEAR);
      end
      add(x);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pend_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
